// ----- rtl/crsc_pkg.sv -----
// Constants and mode codes for the clock-replacement sector cache.
// No dependencies; used by every other file of the block.
package crsc_pkg;
    localparam int ENTRIES     = 64;
    localparam int ENTRY_BITS  = $clog2(ENTRIES);
    localparam int SECTOR_BITS = 32;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    localparam logic [ENTRY_BITS-1:0] LAST_ENTRY = ENTRY_BITS'(ENTRIES - 1);
endpackage

// ----- rtl/crsc_if.sv -----
// Request and response channel interfaces for the sector cache.
// Depends on crsc_pkg for field widths.
interface crsc_req_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       mode;
    logic [crsc_pkg::SECTOR_BITS-1:0] sector;

    modport source (output valid, output mode, output sector, input ready);
    modport sink   (input valid, input mode, input sector, output ready);
endinterface

interface crsc_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [crsc_pkg::ENTRY_BITS-1:0]  entry;
    logic                             hit;
    logic                             fill;
    logic                             writeback;
    logic [crsc_pkg::SECTOR_BITS-1:0] writeback_sector;
    logic                             last;

    modport source (output valid, output entry, output hit, output fill,
                    output writeback, output writeback_sector, output last,
                    input ready);
    modport sink   (input valid, input entry, input hit, input fill,
                    input writeback, input writeback_sector, input last,
                    output ready);
endinterface

// ----- rtl/crsc_tag_mem.sv -----
// Tag store: one write port, one read port with registered read data.
// Depends on crsc_pkg for depth and tag width.
module crsc_tag_mem (
    input  logic                             i_clk,
    input  logic                             i_rd_en,
    input  logic [crsc_pkg::ENTRY_BITS-1:0]  i_rd_addr,
    output logic [crsc_pkg::SECTOR_BITS-1:0] o_rd_data,
    input  logic                             i_wr_en,
    input  logic [crsc_pkg::ENTRY_BITS-1:0]  i_wr_addr,
    input  logic [crsc_pkg::SECTOR_BITS-1:0] i_wr_data
);
    logic [crsc_pkg::SECTOR_BITS-1:0] r_mem [crsc_pkg::ENTRIES];
    logic [crsc_pkg::SECTOR_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- rtl/clock_replacement_sector_cache_top.sv -----
// Clock (second chance) write-back sector cache: tag and policy sequencer.
// Depends on crsc_pkg, crsc_if.sv and crsc_tag_mem.
//
//   channel  dir  handshake      word
//   i_req    in   valid/ready    mode, sector
//   o_rsp    out  valid/ready    entry, hit, fill, writeback, writeback_sector, last
//
// One item at a time; i_req.ready is high only while the sequencer idles.
// Read/write: tag scan one entry per cycle through the tag RAM read port;
// on a miss with every entry valid, a clock sweep picks the victim and
// its tag is read back for a writeback.
// Flush: a full output register stalls the scan.
// Reset clears valid, dirty and reference bits at once; no clearing pass.
module clock_replacement_sector_cache_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crsc_req_if.sink   i_req,
    crsc_rsp_if.source o_rsp
);
    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_SWEEP, S_VREAD, S_VTAG, S_UPD, S_FLUSH, S_FEND
    } t_state;

    localparam int EB = crsc_pkg::ENTRY_BITS;
    localparam int SB = crsc_pkg::SECTOR_BITS;

    t_state                       r_state;
    logic [crsc_pkg::ENTRIES-1:0] r_valid, r_dirty, r_ref;
    logic [EB-1:0]                r_hand, r_h, r_idx, r_cidx, r_slot, r_free_idx;
    logic [EB-1:0]                r_pend_ent;
    logic [SB-1:0]                r_sector, r_wbs, r_pend_wbs;
    logic                         r_is_wr, r_issue, r_cmp_ok, r_free_ok, r_hit;
    logic                         r_fill, r_wb, r_pend_vld;

    logic                         r_out_vld, r_o_hit, r_o_fill, r_o_wb, r_o_last;
    logic [EB-1:0]                r_o_entry;
    logic [SB-1:0]                r_o_wbs;

    logic          rd_en, wr_en, out_free, out_load, hit_now, vd_now, adv;
    logic [EB-1:0] rd_addr, h_nx;
    logic [SB-1:0] rd_tag;

    crsc_tag_mem u_tag_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_tag),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_sector)
    );

    assign out_free = !r_out_vld || o_rsp.ready;
    assign hit_now  = r_cmp_ok && r_valid[r_cidx] && (rd_tag == r_sector);
    assign vd_now   = r_cmp_ok && r_valid[r_cidx] && r_dirty[r_cidx];
    assign h_nx     = (r_h == crsc_pkg::LAST_ENTRY) ? '0 : r_h + 1'b1;
    assign wr_en    = (r_state == S_UPD) && out_free && !r_hit;
    assign out_load = ((r_state == S_UPD) && out_free) ||
                      ((r_state == S_FLUSH) && vd_now && adv && r_pend_vld) ||
                      ((r_state == S_FEND) && out_free);

    always_comb begin
        adv = 1'b1;
        if (r_state == S_FLUSH && vd_now && r_pend_vld && !out_free) begin
            adv = 1'b0;
        end
        rd_en   = 1'b0;
        rd_addr = r_idx;
        case (r_state)
            S_LOOK:  rd_en = r_issue;
            S_FLUSH: rd_en = r_issue && adv;
            S_VREAD: begin
                rd_en   = 1'b1;
                rd_addr = r_slot;
            end
            default: rd_en = 1'b0;
        endcase
    end

    assign i_req.ready            = (r_state == S_IDLE);
    assign o_rsp.valid            = r_out_vld;
    assign o_rsp.entry            = r_o_entry;
    assign o_rsp.hit              = r_o_hit;
    assign o_rsp.fill             = r_o_fill;
    assign o_rsp.writeback        = r_o_wb;
    assign o_rsp.writeback_sector = r_o_wbs;
    assign o_rsp.last             = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_dirty    <= '0;
            r_ref      <= '0;
            r_hand     <= '0;
            r_h        <= '0;
            r_idx      <= '0;
            r_cidx     <= '0;
            r_slot     <= '0;
            r_free_idx <= '0;
            r_pend_ent <= '0;
            r_sector   <= '0;
            r_wbs      <= '0;
            r_pend_wbs <= '0;
            r_is_wr    <= 1'b0;
            r_issue    <= 1'b0;
            r_cmp_ok   <= 1'b0;
            r_free_ok  <= 1'b0;
            r_hit      <= 1'b0;
            r_fill     <= 1'b0;
            r_wb       <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_o_entry  <= '0;
            r_o_hit    <= 1'b0;
            r_o_fill   <= 1'b0;
            r_o_wb     <= 1'b0;
            r_o_wbs    <= '0;
            r_o_last   <= 1'b0;
        end else begin
            if (o_rsp.ready && !out_load) begin
                r_out_vld <= 1'b0;
            end

            // shared scan pipeline: issue address, compare in the next cycle
            if ((r_state == S_LOOK || r_state == S_FLUSH) && adv) begin
                r_cmp_ok <= r_issue;
                if (r_issue) begin
                    r_cidx <= r_idx;
                    if (r_idx == crsc_pkg::LAST_ENTRY) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_sector   <= i_req.sector;
                        r_is_wr    <= (i_req.mode == crsc_pkg::MODE_WRITE);
                        r_idx      <= '0;
                        r_issue    <= 1'b1;
                        r_cmp_ok   <= 1'b0;
                        r_free_ok  <= 1'b0;
                        r_hit      <= 1'b0;
                        r_fill     <= 1'b0;
                        r_wb       <= 1'b0;
                        r_wbs      <= '0;
                        r_pend_vld <= 1'b0;
                        if (i_req.mode == crsc_pkg::MODE_READ ||
                            i_req.mode == crsc_pkg::MODE_WRITE) begin
                            r_state <= S_LOOK;
                        end else if (i_req.mode == crsc_pkg::MODE_FLUSH) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_LOOK: begin
                    if (hit_now) begin
                        r_slot  <= r_cidx;
                        r_hit   <= 1'b1;
                        r_state <= S_UPD;
                    end else if (r_cmp_ok) begin
                        if (!r_valid[r_cidx] && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_cidx;
                        end
                        if (r_cidx == crsc_pkg::LAST_ENTRY) begin
                            r_fill <= 1'b1;
                            if (r_free_ok) begin
                                r_slot  <= r_free_idx;
                                r_state <= S_UPD;
                            end else if (!r_valid[r_cidx]) begin
                                r_slot  <= r_cidx;
                                r_state <= S_UPD;
                            end else begin
                                r_h     <= r_hand;
                                r_state <= S_SWEEP;
                            end
                        end
                    end
                end
                S_SWEEP: begin
                    r_h <= h_nx;
                    if (!r_ref[h_nx]) begin
                        r_hand  <= h_nx;
                        r_slot  <= h_nx;
                        r_state <= S_VREAD;
                    end else begin
                        r_ref[h_nx] <= 1'b0;
                    end
                end
                S_VREAD: begin
                    r_state <= S_VTAG;
                end
                S_VTAG: begin
                    r_wb    <= r_dirty[r_slot];
                    r_wbs   <= r_dirty[r_slot] ? rd_tag : '0;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (out_free) begin
                        r_valid[r_slot] <= 1'b1;
                        r_ref[r_slot]   <= 1'b1;
                        r_dirty[r_slot] <= r_is_wr || (r_hit && r_dirty[r_slot]);
                        r_out_vld <= 1'b1;
                        r_o_entry <= r_slot;
                        r_o_hit   <= r_hit;
                        r_o_fill  <= r_fill;
                        r_o_wb    <= r_wb;
                        r_o_wbs   <= r_wbs;
                        r_o_last  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_FLUSH: begin
                    if (vd_now && adv) begin
                        // hold one found word back so the final one can carry last
                        if (r_pend_vld) begin
                            r_out_vld <= 1'b1;
                            r_o_entry <= r_pend_ent;
                            r_o_hit   <= 1'b0;
                            r_o_fill  <= 1'b0;
                            r_o_wb    <= 1'b1;
                            r_o_wbs   <= r_pend_wbs;
                            r_o_last  <= 1'b0;
                        end
                        r_pend_vld      <= 1'b1;
                        r_pend_ent      <= r_cidx;
                        r_pend_wbs      <= rd_tag;
                        r_dirty[r_cidx] <= 1'b0;
                    end
                    if (r_cmp_ok && adv && r_cidx == crsc_pkg::LAST_ENTRY) begin
                        r_state <= S_FEND;
                    end
                end
                S_FEND: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_o_entry  <= r_pend_vld ? r_pend_ent : '0;
                        r_o_hit    <= 1'b0;
                        r_o_fill   <= 1'b0;
                        r_o_wb     <= r_pend_vld;
                        r_o_wbs    <= r_pend_vld ? r_pend_wbs : '0;
                        r_o_last   <= 1'b1;
                        r_pend_vld <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_o_hit && (r_o_fill || r_o_wb)))
        else $error("hit word with fill or writeback");

    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && out_free) |=> r_valid[$past(r_slot)])
        else $error("updated entry not valid");

    a_hand_moves_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SWEEP) |=> $stable(r_hand))
        else $error("hand moved outside sweep");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !r_pend_vld)
        else $error("flush word left pending at idle");
endmodule

// ----- sim/clock_replacement_sector_cache_top_test.sv -----
// Self-checking testbench for clock_replacement_sector_cache_top: random and directed
// read, write and flush requests are checked against a built-in clock cache model.
// Depends on crsc_pkg, crsc_if.sv and the RTL of the block.
`timescale 1ns / 1ps

module clock_replacement_sector_cache_top_test;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 390;
    localparam int POOL_SIZE      = 80;
    localparam int CALM_ITEMS     = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 300;

    typedef struct packed {
        logic [1:0]                       mode;
        logic [crsc_pkg::SECTOR_BITS-1:0] sector;
    } t_req_word;

    typedef struct packed {
        logic [crsc_pkg::ENTRY_BITS-1:0]  entry;
        logic                             hit;
        logic                             fill;
        logic                             writeback;
        logic [crsc_pkg::SECTOR_BITS-1:0] writeback_sector;
        logic                             last;
    } t_cache_resp;

    logic i_clk;
    logic i_rst_n;

    crsc_req_if req_if ();
    crsc_rsp_if rsp_if ();

    clock_replacement_sector_cache_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // cache model state
    logic [crsc_pkg::SECTOR_BITS-1:0] tag_q   [crsc_pkg::ENTRIES];
    logic                             valid_q [crsc_pkg::ENTRIES];
    logic                             dirty_q [crsc_pkg::ENTRIES];
    logic                             refer_q [crsc_pkg::ENTRIES];
    logic [crsc_pkg::ENTRY_BITS-1:0]  hand_q;

    t_req_word   pending_reqs[$];
    t_cache_resp expected_resps[$];
    logic [crsc_pkg::SECTOR_BITS-1:0] sector_pool [POOL_SIZE];

    int total_reqs;
    int accepted_reqs;
    int checked_words;
    int errors;
    int hits;
    int evictions;
    int writebacks;
    int flushes;
    int gap_cycles;
    int stall_cycles;
    int idle_cycles;
    logic calm = 1'b0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic void predict_cache(input logic [1:0] mode,
                                          input logic [crsc_pkg::SECTOR_BITS-1:0] sector);
        t_cache_resp r;
        int last_dirty;
        int slot;
        logic found;
        logic got;
        logic done;
        logic [crsc_pkg::ENTRY_BITS-1:0] h;

        r = '0;
        if (mode == crsc_pkg::MODE_FLUSH) begin
            flushes++;
            last_dirty = -1;
            for (int i = 0; i < crsc_pkg::ENTRIES; i++)
                if (valid_q[i] && dirty_q[i]) last_dirty = i;
            if (last_dirty < 0) begin
                r.last = 1'b1;
                expected_resps.push_back(r);
                return;
            end
            for (int i = 0; i < crsc_pkg::ENTRIES; i++) begin
                if (valid_q[i] && dirty_q[i]) begin
                    r.entry            = crsc_pkg::ENTRY_BITS'(i);
                    r.writeback        = 1'b1;
                    r.writeback_sector = tag_q[i];
                    r.last             = (i == last_dirty);
                    expected_resps.push_back(r);
                    dirty_q[i] = 1'b0;
                end
            end
            return;
        end
        if (mode == MODE_UNUSED) return;

        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < crsc_pkg::ENTRIES && !found; i++) begin
            if (valid_q[i] && tag_q[i] == sector) begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (found) begin
            hits++;
        end else begin
            r.fill = 1'b1;
            got = 1'b0;
            for (int i = 0; i < crsc_pkg::ENTRIES && !got; i++) begin
                if (!valid_q[i]) begin
                    slot = i;
                    got  = 1'b1;
                end
            end
            if (!got) begin
                evictions++;
                h    = hand_q;
                done = 1'b0;
                while (!done) begin
                    h = (h == crsc_pkg::LAST_ENTRY) ? '0 : h + 1'b1;
                    if (!refer_q[h]) done = 1'b1;
                    else refer_q[h] = 1'b0;
                end
                hand_q = h;
                slot   = int'(h);
                if (dirty_q[slot]) begin
                    writebacks++;
                    r.writeback        = 1'b1;
                    r.writeback_sector = tag_q[slot];
                end
            end
            tag_q[slot]   = sector;
            valid_q[slot] = 1'b1;
            dirty_q[slot] = 1'b0;
        end
        refer_q[slot] = 1'b1;
        if (mode == crsc_pkg::MODE_WRITE) dirty_q[slot] = 1'b1;
        r.entry = crsc_pkg::ENTRY_BITS'(slot);
        r.hit   = found;
        r.last  = 1'b1;
        expected_resps.push_back(r);
    endfunction

    task automatic queue_req(input logic [1:0] mode,
                             input logic [crsc_pkg::SECTOR_BITS-1:0] sector);
        t_req_word w;
        w.mode   = mode;
        w.sector = sector;
        pending_reqs.push_back(w);
    endtask

    function automatic logic [crsc_pkg::SECTOR_BITS-1:0] pick_sector();
        if ($urandom_range(0, 19) == 0) return $urandom;
        return sector_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_req_word w;
        if (!i_rst_n) begin
            req_if.valid  <= 1'b0;
            req_if.mode   <= crsc_pkg::MODE_READ;
            req_if.sector <= '0;
            gap_cycles    = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_cache(req_if.mode, req_if.sector);
                accepted_reqs++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap_cycles > 0) begin
                    gap_cycles--;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    w = pending_reqs.pop_front();
                    req_if.valid  <= 1'b1;
                    req_if.mode   <= w.mode;
                    req_if.sector <= w.sector;
                    calm <= (pending_reqs.size() < CALM_ITEMS);
                    if (!calm && $urandom_range(0, 3) == 0)
                        gap_cycles = $urandom_range(1, 8);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        t_cache_resp want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_cycles = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                checked_words++;
                if (expected_resps.size() == 0) begin
                    $error("unexpected response word: entry %0d", rsp_if.entry);
                    errors++;
                end else begin
                    want = expected_resps.pop_front();
                    if (rsp_if.entry !== want.entry) begin
                        $error("entry: expected %0d, actual %0d", want.entry, rsp_if.entry);
                        errors++;
                    end
                    if (rsp_if.hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, rsp_if.hit);
                        errors++;
                    end
                    if (rsp_if.fill !== want.fill) begin
                        $error("fill: expected %0d, actual %0d", want.fill, rsp_if.fill);
                        errors++;
                    end
                    if (rsp_if.writeback !== want.writeback) begin
                        $error("writeback: expected %0d, actual %0d",
                               want.writeback, rsp_if.writeback);
                        errors++;
                    end
                    if (rsp_if.writeback_sector !== want.writeback_sector) begin
                        $error("writeback_sector: expected %08h, actual %08h",
                               want.writeback_sector, rsp_if.writeback_sector);
                        errors++;
                    end
                    if (rsp_if.last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, rsp_if.last);
                        errors++;
                    end
                end
            end
            if (stall_cycles > 0) begin
                stall_cycles--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_cycles = $urandom_range(1, 8);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int counted;
        int pick;
        int len;
        int base;
        logic [crsc_pkg::SECTOR_BITS-1:0] s;

        i_rst_n = 1'b0;
        hand_q  = '0;
        for (int i = 0; i < crsc_pkg::ENTRIES; i++) begin
            tag_q[i]   = '0;
            valid_q[i] = 1'b0;
            dirty_q[i] = 1'b0;
            refer_q[i] = 1'b0;
        end
        sector_pool[0] = '0;
        sector_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) sector_pool[i] = $urandom;

        // directed: extremes, hits, flush with and without dirty lines, unused mode
        queue_req(crsc_pkg::MODE_FLUSH, 32'h0000_0000);
        queue_req(crsc_pkg::MODE_READ,  32'h0000_0000);
        queue_req(crsc_pkg::MODE_WRITE, 32'hFFFF_FFFF);
        queue_req(crsc_pkg::MODE_READ,  32'h0000_0000);
        queue_req(crsc_pkg::MODE_WRITE, 32'h0000_0000);
        queue_req(crsc_pkg::MODE_FLUSH, 32'hFFFF_FFFF);
        queue_req(crsc_pkg::MODE_FLUSH, 32'h1234_5678);
        queue_req(MODE_UNUSED,          32'hA5A5_A5A5);
        queue_req(crsc_pkg::MODE_READ,  32'hA5A5_A5A5);
        queue_req(crsc_pkg::MODE_WRITE, 32'h5A5A_5A5A);
        queue_req(crsc_pkg::MODE_READ,  32'hFFFF_FFFF);
        queue_req(crsc_pkg::MODE_WRITE, 32'hA5A5_A5A5);
        queue_req(crsc_pkg::MODE_READ,  32'h8000_0000);
        queue_req(crsc_pkg::MODE_WRITE, 32'h0000_0001);
        queue_req(crsc_pkg::MODE_READ,  32'h0000_0001);
        queue_req(crsc_pkg::MODE_FLUSH, 32'h0000_0000);
        queue_req(crsc_pkg::MODE_WRITE, 32'h7FFF_FFFF);
        queue_req(crsc_pkg::MODE_FLUSH, 32'h0000_0000);

        // random: mostly pool traffic so the cache fills and the clock sweeps
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = $urandom_range(1, 16);
                repeat (len) begin
                    queue_req(($urandom_range(0, 9) < 4) ? crsc_pkg::MODE_WRITE
                                                         : crsc_pkg::MODE_READ,
                              pick_sector());
                    counted++;
                end
            end else if (pick < 82) begin
                queue_req(crsc_pkg::MODE_FLUSH, $urandom);
                counted++;
            end else if (pick < 85) begin
                // dirty a whole cache worth of lines, then flush them all
                base = $urandom_range(0, POOL_SIZE - 1);
                for (int k = 0; k < crsc_pkg::ENTRIES; k++)
                    queue_req(crsc_pkg::MODE_WRITE, sector_pool[(base + k) % POOL_SIZE]);
                queue_req(crsc_pkg::MODE_FLUSH, $urandom);
                counted += crsc_pkg::ENTRIES + 1;
            end else if (pick < 90) begin
                queue_req(MODE_UNUSED, $urandom);
                counted++;
            end else begin
                s = $urandom;
                queue_req(crsc_pkg::MODE_READ, s);
                queue_req(crsc_pkg::MODE_WRITE, s);
                queue_req(crsc_pkg::MODE_READ, s);
                counted += 3;
            end
        end
        total_reqs = pending_reqs.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_reqs != total_reqs || expected_resps.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d requests (%0d flushes), %0d hits, %0d clock evictions,",
                 accepted_reqs, flushes, hits, evictions);
        $display("run: %0d writebacks, %0d response words checked, %0d mismatches",
                 writebacks, checked_words, errors);
        if (errors == 0 && expected_resps.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
